// ===== src/glsp_pkg.sv =====
// Package for the generational lease slot pool: request and result beat types,
// request and status codes, and default sizing constants. No dependencies.
package glsp_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int GEN_BITS_DEF = 32;
	localparam int CAP_BITS = 5;

	typedef enum logic [2:0] {
		REQ_RESERVE = 3'd0,
		REQ_ACQUIRE = 3'd1,
		REQ_RELEASE = 3'd2,
		REQ_CANCEL  = 3'd3,
		REQ_FCLEAR  = 3'd4
	} req_code_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SLOT  = 3'd1,
		ST_NONE_FREE = 3'd2,
		ST_REJECTED  = 3'd3,
		ST_FULL      = 3'd4,
		ST_UNDERFLOW = 3'd5
	} status_code_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  slot_index;
		logic [31:0] generation;
		logic [15:0] pend_load;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  result_slot;
		logic [31:0] result_generation;
		logic [15:0] result_refcount;
		logic [15:0] result_pending;
	} rsp_t;

endpackage

// ===== src/generational_lease_slot_pool.sv =====
// Generational lease slot pool top level: front checker, request queue,
// table back end and result queue. Depends on glsp_pkg and its submodules.
// Path: front register, request queue, back end's busy register, result queue. The back end
// takes no new request until its read-then-commit step has handed the last result on.
// Reset clears all slot tables, the search pointer and the queues at once;
// the capacity register cap_q resets to 16.
module generational_lease_slot_pool #(
	parameter int SLOTS = glsp_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = glsp_pkg::COUNT_BITS_DEF,
	parameter int GEN_BITS = glsp_pkg::GEN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  glsp_pkg::req_t                req,
	output logic                          full,
	output logic                          empty,
	input  logic                          pop,
	output glsp_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [glsp_pkg::CAP_BITS-1:0] cfg_data
);
	import glsp_pkg::*;

	localparam int QW = $bits(req_t) + 1;

	logic [CAP_BITS-1:0] cap_q;
	logic   f_vld, f_rdy, f_bad;
	req_t   f_req;
	logic   q_full, q_empty, b_rdy, b_vld, r_full;
	logic [QW-1:0] q_dout;
	rsp_t   b_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_BITS'(16);
		else if (cfg_we) cap_q <= cfg_data;
	end

	assign full = !f_rdy;

	glsp_front #(.SLOTS(SLOTS)) u_front (
		.clk, .arst_n, .cap(cap_q),
		.in_valid(push), .in_req(req), .in_ready(f_rdy),
		.out_valid(f_vld), .out_req(f_req), .out_bad(f_bad), .out_ready(!q_full)
	);

	glsp_fifo #(.W(QW)) u_q (
		.clk, .arst_n, .push(f_vld), .din({f_req, f_bad}), .full(q_full),
		.pop(b_rdy), .dout(q_dout), .empty(q_empty)
	);

	glsp_back #(.SLOTS(SLOTS), .COUNT_BITS(COUNT_BITS), .GEN_BITS(GEN_BITS)) u_back (
		.clk, .arst_n, .cap(cap_q),
		.in_valid(!q_empty), .in_req(q_dout[QW-1:1]), .in_bad(q_dout[0]),
		.in_ready(b_rdy),
		.out_valid(b_vld), .out_rsp(b_rsp), .out_ready(!r_full)
	);

	glsp_fifo #(.W($bits(rsp_t))) u_rq (
		.clk, .arst_n, .push(b_vld), .din(b_rsp), .full(r_full),
		.pop, .dout(rsp), .empty
	);

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> cap_q == $past(cfg_data))
		else $error("capacity write lost");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> u_front.out_valid)
		else $error("full without a held request");
	a_res_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result vanished");
endmodule

// ===== src/glsp_fifo.sv =====
// Small two-entry queue between the front and the back, and on the result side.
// No dependencies; the payload width is handed in as a parameter.
module glsp_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         do_push, do_pop;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> full || $past(do_push) == 1'b0)
		else $error("queue overflow");
	a_ptr_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q)
		else $error("queue pointers out of step");
endmodule

// ===== src/glsp_front.sv =====
// Front stage: takes request beats, checks the slot range of each non-reserve request
// against the capacity and tags it as bad-slot or go. Depends on glsp_pkg.
module glsp_front #(
	parameter int SLOTS = glsp_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [glsp_pkg::CAP_BITS-1:0]   cap,
	input  logic                            in_valid,
	input  glsp_pkg::req_t                  in_req,
	output logic                            in_ready,
	output logic                            out_valid,
	output glsp_pkg::req_t                  out_req,
	output logic                            out_bad,
	input  logic                            out_ready
);
	import glsp_pkg::*;

	req_t req_s1;
	logic bad_s1, vld_s1;
	logic bad;

	// capacity is the smaller of the register and the table size
	assign bad = (in_req.req_type != REQ_RESERVE) &&
		(({1'b0, in_req.slot_index} >= cap) || (int'(in_req.slot_index) >= SLOTS));
	assign in_ready = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_req = req_s1;
	assign out_bad = bad_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
			bad_s1 <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (in_ready) vld_s1 <= in_valid;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !out_ready |=> vld_s1 && $stable(req_s1))
		else $error("front dropped a stalled request");
	a_bad_res: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && req_s1.req_type == REQ_RESERVE |-> !bad_s1)
		else $error("reserve flagged bad slot");
	a_slots: assert property (@(posedge clk) SLOTS >= 1)
		else $error("no slots");
endmodule

// ===== src/glsp_back.sv =====
// Back stage: holds the slot tables and executes one request at a time (read/scan,
// then write and result, the write waiting while the result side stalls). Depends on glsp_pkg.
module glsp_back #(
	parameter int SLOTS = glsp_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = glsp_pkg::COUNT_BITS_DEF,
	parameter int GEN_BITS = glsp_pkg::GEN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [glsp_pkg::CAP_BITS-1:0] cap,
	input  logic                          in_valid,
	input  glsp_pkg::req_t                in_req,
	input  logic                          in_bad,
	output logic                          in_ready,
	output logic                          out_valid,
	output glsp_pkg::rsp_t                out_rsp,
	input  logic                          out_ready
);
	import glsp_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = IW + 1;
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	logic [GEN_BITS-1:0]   gen_q [SLOTS];
	logic [COUNT_BITS-1:0] ref_q [SLOTS];
	logic [COUNT_BITS-1:0] pnd_q [SLOTS];
	logic [PW-1:0]         ptr_q;
	logic                  busy_q;
	req_t                  req_q;
	logic                  bad_q;

	logic [PW-1:0] capw, start;
	logic [SLOTS-1:0] freev;
	logic          found;
	logic [PW-1:0] pick;
	logic [IW-1:0] sidx;
	logic [GEN_BITS-1:0]   g;
	logic [COUNT_BITS-1:0] r, p, nr, np;
	logic [GEN_BITS-1:0]   ng;
	logic [2:0]  st;
	logic        wr;
	logic [PW-1:0] nptr;
	logic [COUNT_BITS-1:0] load;
	rsp_t rsp;

	assign capw = (int'(cap) > SLOTS) ? PW'(SLOTS) : PW'(cap);
	assign start = (ptr_q < capw) ? ptr_q : '0;
	assign in_ready = !busy_q;
	assign out_valid = busy_q;
	assign out_rsp = rsp;

	always_comb begin
		for (int i = 0; i < SLOTS; i++)
			freev[i] = (PW'(i) < capw) && ref_q[i] == '0 && pnd_q[i] == '0;
	end

	// Rotating priority pick: first free slot at or after start, else first overall.
	always_comb begin
		logic hi_f, lo_f;
		logic [PW-1:0] hi_i, lo_i;
		hi_f = 1'b0; lo_f = 1'b0; hi_i = '0; lo_i = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (freev[i]) begin
				lo_f = 1'b1; lo_i = PW'(i);
				if (PW'(i) >= start) begin
					hi_f = 1'b1; hi_i = PW'(i);
				end
			end
		end
		found = hi_f || lo_f;
		pick = hi_f ? hi_i : lo_i;
	end

	always_comb begin
		sidx = (req_q.req_type == REQ_RESERVE) ? pick[IW-1:0] : req_q.slot_index[IW-1:0];
		g = gen_q[sidx];
		r = ref_q[sidx];
		p = pnd_q[sidx];
		ng = g; nr = r; np = p;
		st = ST_OK;
		wr = 1'b0;
		nptr = ptr_q;
		if (COUNT_BITS >= 16) load = COUNT_BITS'(req_q.pend_load);
		else load = (req_q.pend_load > 16'(CMAX)) ? CMAX
			: COUNT_BITS'(req_q.pend_load);
		rsp = '0;
		if (req_q.req_type == REQ_RESERVE) begin
			if (capw == '0) begin
				st = ST_NONE_FREE;
			end else if (!found) begin
				st = ST_NONE_FREE;
				nptr = (start + 1'b1 >= capw) ? '0 : start + 1'b1;
			end else begin
				wr = 1'b1;
				ng = g + 1'b1;
				np = load;
				nptr = (pick + 1'b1 >= capw) ? '0 : pick + 1'b1;
			end
			rsp.status = st;
			if (st == ST_OK) begin
				rsp.result_slot = 4'(pick);
				rsp.result_generation = 32'(ng);
				rsp.result_refcount = 16'(nr);
				rsp.result_pending = 16'(np);
			end
		end else begin
			if (bad_q) begin
				st = ST_BAD_SLOT;
			end else begin
				unique case (req_q.req_type)
					REQ_ACQUIRE: begin
						if (g != GEN_BITS'(req_q.generation)) st = ST_REJECTED;
						else if (r == CMAX) st = ST_FULL;
						else begin
							wr = 1'b1; nr = r + 1'b1;
							if (p != '0) np = p - 1'b1;
						end
					end
					REQ_RELEASE: begin
						if (r == '0) st = ST_UNDERFLOW;
						else begin wr = 1'b1; nr = r - 1'b1; end
					end
					REQ_CANCEL: begin
						if (g != GEN_BITS'(req_q.generation) || r != '0) st = ST_REJECTED;
						else begin wr = 1'b1; np = '0; end
					end
					REQ_FCLEAR: begin
						if (p != '0) begin
							if (r != '0) st = ST_REJECTED;
							else begin wr = 1'b1; np = '0; end
						end
					end
					default: st = ST_REJECTED;
				endcase
			end
			rsp.status = st;
			rsp.result_slot = req_q.slot_index;
			if (!bad_q) begin
				rsp.result_generation = 32'(ng);
				rsp.result_refcount = 16'(nr);
				rsp.result_pending = 16'(np);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !busy_q) begin
			req_q <= in_req;
			bad_q <= in_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ptr_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				gen_q[i] <= '0; ref_q[i] <= '0; pnd_q[i] <= '0;
			end
		end else if (busy_q) begin
			if (out_ready) begin
				busy_q <= 1'b0;
				ptr_q <= nptr;
				if (wr) begin
					gen_q[sidx] <= ng; ref_q[sidx] <= nr; pnd_q[sidx] <= np;
				end
			end
		end else begin
			busy_q <= in_valid;
		end
	end

	a_ptr: assert property (@(posedge clk) disable iff (!arst_n) ptr_q <= PW'(SLOTS))
		else $error("search pointer out of range");
	a_ok_free: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && req_q.req_type == REQ_RESERVE && st == ST_OK |-> r == '0 && p == '0)
		else $error("reserve picked a busy slot");
	a_bad_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && bad_q |-> !wr)
		else $error("bad slot changed state");
endmodule
